>>> rtl/core/smsk_pkg.sv
`timescale 1ns / 1ps
// Shared types and state codes for the stable merge sort block.
// No dependencies; all files but smsk_stream_if refer to it by scoped names.
package smsk_pkg;

    localparam int KEY_W = 32;
    localparam int TAG_W = 16;

    // One item as it arrives on the input channel.
    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [TAG_W-1:0]        tag;
        logic                    last_in;
    } in_item_t;

    // One item as it leaves on the result channel.
    typedef struct packed {
        logic signed [KEY_W-1:0] sorted_key;
        logic [TAG_W-1:0]        sorted_tag;
        logic                    last_out;
        logic                    overflow;
    } out_item_t;

    // One stored entry of a bank.
    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [TAG_W-1:0]        tag;
    } entry_t;

    // Write enables of the two banks.
    typedef struct packed {
        logic bank1;
        logic bank0;
    } bank_we_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_PASS_INIT,
        ST_MERGE_RD,
        ST_MERGE_WR,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_EMIT_WAIT
    } state_t;

endpackage

>>> rtl/core/smsk_stream_if.sv
`timescale 1ns / 1ps
// Valid/ready stream channel used for both the item and the result channel.
// The payload type is a parameter; the types come from smsk_pkg.
interface smsk_stream_if #(
    parameter type payload_t = logic
) ();

    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);

endinterface

>>> rtl/core/smsk_bank.sv
`timescale 1ns / 1ps
// One bank of item storage: one write port and two registered read ports.
// Depends on smsk_pkg for the entry type.
module smsk_bank #(
    parameter int DEPTH = 64
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [$clog2(DEPTH)-1:0]   waddr,
    input  smsk_pkg::entry_t           wdata,
    input  logic [$clog2(DEPTH)-1:0]   raddr_a,
    input  logic [$clog2(DEPTH)-1:0]   raddr_b,
    output smsk_pkg::entry_t           rdata_a,
    output smsk_pkg::entry_t           rdata_b
);

    smsk_pkg::entry_t mem [DEPTH];
    smsk_pkg::entry_t rdata_a_reg;
    smsk_pkg::entry_t rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a_reg <= mem[raddr_a];
        rdata_b_reg <= mem[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

>>> rtl/core/smsk_cmp.sv
`timescale 1ns / 1ps
// Shared merge decision unit: picks the left run on a less-or-equal key,
// which keeps the sort stable. Depends on smsk_pkg for the entry type.
module smsk_cmp (
    input  smsk_pkg::entry_t left,
    input  smsk_pkg::entry_t right,
    input  logic             left_avail,
    input  logic             right_avail,
    output logic             take_left
);

    logic key_le;

    assign key_le    = (left.key <= right.key);
    assign take_left = left_avail && (!right_avail || key_le);

endmodule

>>> rtl/core/smsk_ctrl.sv
`timescale 1ns / 1ps
// Sequencer of the sort: load, bottom-up merge passes between two banks, emit.
// Depends on smsk_pkg and smsk_stream_if; drives the banks and uses smsk_cmp.
module smsk_ctrl #(
    parameter int MAX_ITEMS = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    smsk_stream_if.sink                   items,
    smsk_stream_if.source                 results,
    output smsk_pkg::bank_we_t            bank_we,
    output logic [$clog2(MAX_ITEMS)-1:0]  waddr,
    output smsk_pkg::entry_t              wdata,
    output logic [$clog2(MAX_ITEMS)-1:0]  raddr_a,
    output logic [$clog2(MAX_ITEMS)-1:0]  raddr_b,
    input  smsk_pkg::entry_t              bank0_a,
    input  smsk_pkg::entry_t              bank0_b,
    input  smsk_pkg::entry_t              bank1_a,
    input  smsk_pkg::entry_t              bank1_b
);

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int SW = CW + 1;

    smsk_pkg::state_t  state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              ovf_reg, ovf_next;
    logic [CW-1:0]     n_reg, n_next;
    logic [SW-1:0]     width_reg, width_next;
    logic [SW-1:0]     mid_reg, mid_next;
    logic [SW-1:0]     hi_reg, hi_next;
    logic [SW-1:0]     l_reg, l_next;
    logic [SW-1:0]     r_reg, r_next;
    logic [CW-1:0]     o_reg, o_next;
    logic [CW-1:0]     e_reg, e_next;
    logic              src_reg, src_next;
    smsk_pkg::out_item_t out_reg, out_next;
    logic              out_valid_reg, out_valid_next;

    smsk_pkg::entry_t  src_a;
    smsk_pkg::entry_t  src_b;
    logic              take_left;
    logic              has_room;
    logic              in_xfer;
    logic              out_xfer;
    logic [SW-1:0]     n_ext;
    logic [SW-1:0]     o_inc;
    logic [SW-1:0]     seg_mid;
    logic [SW-1:0]     seg_hi;
    logic [SW-1:0]     first_mid;
    logic [SW-1:0]     first_hi;

    assign src_a    = src_reg ? bank1_a : bank0_a;
    assign src_b    = src_reg ? bank1_b : bank0_b;
    assign has_room = (count_reg < CW'(MAX_ITEMS));
    assign in_xfer  = items.valid && items.ready;
    assign out_xfer = results.valid && results.ready;
    assign n_ext    = SW'(n_reg);
    assign o_inc    = SW'(o_reg) + SW'(1);

    // Bounds of the next segment and of the first one, clipped to the list.
    assign seg_mid   = ((hi_reg + width_reg) > n_ext) ? n_ext : (hi_reg + width_reg);
    assign seg_hi    = ((hi_reg + (width_reg << 1)) > n_ext) ? n_ext
                                                             : (hi_reg + (width_reg << 1));
    assign first_mid = (width_reg > n_ext) ? n_ext : width_reg;
    assign first_hi  = ((width_reg << 1) > n_ext) ? n_ext : (width_reg << 1);

    smsk_cmp u_cmp (
        .left        (src_a),
        .right       (src_b),
        .left_avail  (l_reg < mid_reg),
        .right_avail (r_reg < hi_reg),
        .take_left   (take_left)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= smsk_pkg::ST_LOAD;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        width_reg <= width_next;
        mid_reg   <= mid_next;
        hi_reg    <= hi_next;
        l_reg     <= l_next;
        r_reg     <= r_next;
        o_reg     <= o_next;
        e_reg     <= e_next;
        src_reg   <= src_next;
        out_reg   <= out_next;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            smsk_pkg::ST_LOAD:
            begin
                if (in_xfer && items.data.last_in)
                begin
                    state_next = smsk_pkg::ST_PASS_INIT;
                end
            end
            smsk_pkg::ST_PASS_INIT:
            begin
                if (n_reg == '0)
                begin
                    state_next = smsk_pkg::ST_LOAD;
                end
                else if (width_reg >= n_ext)
                begin
                    state_next = smsk_pkg::ST_EMIT_RD;
                end
                else
                begin
                    state_next = smsk_pkg::ST_MERGE_RD;
                end
            end
            smsk_pkg::ST_MERGE_RD:
            begin
                state_next = smsk_pkg::ST_MERGE_WR;
            end
            smsk_pkg::ST_MERGE_WR:
            begin
                if (o_inc == n_ext)
                begin
                    state_next = smsk_pkg::ST_PASS_INIT;
                end
                else
                begin
                    state_next = smsk_pkg::ST_MERGE_RD;
                end
            end
            smsk_pkg::ST_EMIT_RD:
            begin
                state_next = smsk_pkg::ST_EMIT_LD;
            end
            smsk_pkg::ST_EMIT_LD:
            begin
                state_next = smsk_pkg::ST_EMIT_WAIT;
            end
            smsk_pkg::ST_EMIT_WAIT:
            begin
                if (out_xfer)
                begin
                    state_next = out_reg.last_out ? smsk_pkg::ST_LOAD : smsk_pkg::ST_EMIT_RD;
                end
            end
            default:
            begin
                state_next = smsk_pkg::ST_LOAD;
            end
        endcase
    end

    // Datapath and outputs.
    always_comb
    begin
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        n_next         = n_reg;
        width_next     = width_reg;
        mid_next       = mid_reg;
        hi_next        = hi_reg;
        l_next         = l_reg;
        r_next         = r_reg;
        o_next         = o_reg;
        e_next         = e_reg;
        src_next       = src_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        bank_we        = '0;
        waddr          = count_reg[AW-1:0];
        wdata          = '{key: items.data.key, tag: items.data.tag};
        raddr_a        = l_reg[AW-1:0];
        raddr_b        = r_reg[AW-1:0];
        items.ready    = 1'b0;

        unique case (state_reg)
            smsk_pkg::ST_LOAD:
            begin
                items.ready = 1'b1;
                if (in_xfer)
                begin
                    if (has_room)
                    begin
                        bank_we.bank0 = 1'b1;
                        count_next    = count_reg + CW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (items.data.last_in)
                    begin
                        n_next     = has_room ? (count_reg + CW'(1)) : count_reg;
                        width_next = SW'(1);
                        src_next   = 1'b0;
                    end
                end
            end
            smsk_pkg::ST_PASS_INIT:
            begin
                l_next   = '0;
                r_next   = first_mid;
                mid_next = first_mid;
                hi_next  = first_hi;
                o_next   = '0;
                e_next   = '0;
                if (n_reg == '0)
                begin
                    count_next = '0;
                    ovf_next   = 1'b0;
                end
            end
            smsk_pkg::ST_MERGE_RD:
            begin
            end
            smsk_pkg::ST_MERGE_WR:
            begin
                waddr = o_reg[AW-1:0];
                wdata = take_left ? src_a : src_b;
                if (src_reg)
                begin
                    bank_we.bank0 = 1'b1;
                end
                else
                begin
                    bank_we.bank1 = 1'b1;
                end
                o_next = o_inc[CW-1:0];
                if (take_left)
                begin
                    l_next = l_reg + SW'(1);
                end
                else
                begin
                    r_next = r_reg + SW'(1);
                end
                if (o_inc == n_ext)
                begin
                    src_next   = !src_reg;
                    width_next = width_reg << 1;
                end
                else if (o_inc == hi_reg)
                begin
                    l_next   = hi_reg;
                    r_next   = seg_mid;
                    mid_next = seg_mid;
                    hi_next  = seg_hi;
                end
            end
            smsk_pkg::ST_EMIT_RD:
            begin
                raddr_a = e_reg[AW-1:0];
            end
            smsk_pkg::ST_EMIT_LD:
            begin
                raddr_a        = e_reg[AW-1:0];
                out_next       = '{sorted_key: src_a.key, sorted_tag: src_a.tag,
                                   last_out: ((e_reg + CW'(1)) == n_reg), overflow: ovf_reg};
                out_valid_next = 1'b1;
            end
            smsk_pkg::ST_EMIT_WAIT:
            begin
                raddr_a = e_reg[AW-1:0];
                if (out_xfer)
                begin
                    out_valid_next = 1'b0;
                    e_next         = e_reg + CW'(1);
                    if (out_reg.last_out)
                    begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    assign results.valid = out_valid_reg;
    assign results.data  = out_reg;

endmodule

>>> rtl/core/stable_merge_sort_by_key_top.sv
`timescale 1ns / 1ps
// Top level of the stable merge sort block: two storage banks and the sequencer.
// Depends on smsk_pkg, smsk_stream_if, smsk_bank, smsk_cmp and smsk_ctrl.
//
// Usage: items arrive on the items channel (key, tag, last_in), one transfer per
// cycle while the block is loading. The item that carries last_in closes the list;
// up to MAX_ITEMS items are kept, and any further item is dropped and raises the
// overflow bit on every result of that list. After the closing transfer the block
// drops ready, sorts the list into ascending signed key order (equal keys keep their
// arrival order) and sends every item on the results channel, with last_out on the
// final one.
// Work for a list of n items: the load, then ceil(log2(n)) merge passes, then
// the results, each read, loaded into the output register and held until taken.
// The merge speed is set by the single compare unit and the registered read ports
// of the banks: each merged item is read in ST_MERGE_RD and written in ST_MERGE_WR.
// Results sit in an output register; when the receiver stalls, the result holds
// until it is taken, and the block moves on only after that transfer.
// Reset clears the sequencer, the item count and the overflow flag; the banks
// are not cleared, since only entries written for the current list are read.
// After the last result the block is ready for a new list at once.
module stable_merge_sort_by_key_top #(
    parameter int MAX_ITEMS = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    smsk_stream_if.sink   items,
    smsk_stream_if.source results
);

    localparam int AW = $clog2(MAX_ITEMS);

    smsk_pkg::bank_we_t bank_we;
    logic [AW-1:0]      waddr;
    smsk_pkg::entry_t   wdata;
    logic [AW-1:0]      raddr_a;
    logic [AW-1:0]      raddr_b;
    smsk_pkg::entry_t   bank0_a;
    smsk_pkg::entry_t   bank0_b;
    smsk_pkg::entry_t   bank1_a;
    smsk_pkg::entry_t   bank1_b;

    // Bank 0 takes the loaded list; each merge pass moves the data to the other bank.
    smsk_bank #(
        .DEPTH (MAX_ITEMS)
    ) u_bank0 (
        .clk     (clk),
        .we      (bank_we.bank0),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (bank0_a),
        .rdata_b (bank0_b)
    );

    smsk_bank #(
        .DEPTH (MAX_ITEMS)
    ) u_bank1 (
        .clk     (clk),
        .we      (bank_we.bank1),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (bank1_a),
        .rdata_b (bank1_b)
    );

    // The sequencer runs the load, the merge passes and the output transfers.
    smsk_ctrl #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items),
        .results (results),
        .bank_we (bank_we),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .bank0_a (bank0_a),
        .bank0_b (bank0_b),
        .bank1_a (bank1_a),
        .bank1_b (bank1_b)
    );

endmodule
